/* sv/skda_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Six-key debounce and auto-repeat: shared package
// Widths, register map, reset values and the types passed between modules.
// ---------------------------------------------------------------------------
package skda_pkg;

  // Number of key lanes; pins and mask bits past the fields read as pressed / off.
  localparam int KEY_COUNT = 6;

  // Field widths.
  localparam int TIME_W = 32;
  localparam int PIN_W  = 6;
  localparam int CFG_W  = 16;
  localparam int MASK_W = 6;
  localparam int EVT_W  = 3;

  // Register port geometry.
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_RPT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RPT_INTVL  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RPT_MASK   = 2'd3;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0]  RST_DEBOUNCE  = 16'd30;
  localparam logic [CFG_W-1:0]  RST_FIRST_RPT = 16'd450;
  localparam logic [CFG_W-1:0]  RST_RPT_INTVL = 16'd140;
  localparam logic [MASK_W-1:0] RST_RPT_MASK  = 6'd15;

  // Timing settings shared by every lane.
  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] first_rpt;
    logic [CFG_W-1:0] rpt_intvl;
  } cfg_t;

  // Result of the priority merge across lanes.
  typedef struct packed {
    logic [KEY_COUNT-1:0] first;   // one-hot: lane that ends the poll
    logic [KEY_COUNT-1:0] commit;  // lanes whose state updates on this poll
    logic [EVT_W-1:0]     code;    // event code, zero for none
  } merge_t;

endpackage

/* sv/skda_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Six-key debounce and auto-repeat: key lane
// Holds one key's state, works out its next state for the current poll and
// flags whether this key yields an event. The state is written only when the
// merge stage allows it.
// ---------------------------------------------------------------------------
module skda_lane import skda_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TIME_W-1:0] now,
  input  logic              pressed,
  input  cfg_t              cfg,
  input  logic              rpt_en,
  input  logic              upd,
  output logic              hit
);

  logic              raw_r, raw_nxt;
  logic              deb_r, deb_nxt;
  logic [TIME_W-1:0] lct_r, lct_nxt;
  logic [TIME_W-1:0] dl_r, dl_nxt;
  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] overdue;
  logic              accepted;
  logic              repeat_due;

  // Raw change tracking: a change restarts the stability timer.
  always_comb begin
    raw_nxt = pressed;
    lct_nxt = (pressed != raw_r) ? now : lct_r;
  end

  // Debounce: accept the raw level once it has held long enough.
  assign since    = now - lct_nxt;
  assign accepted = (pressed != deb_r) && (since >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce});
  assign deb_nxt  = accepted ? pressed : deb_r;

  // Auto-repeat: signed wrap compare against the deadline. An accepted release
  // clears the held level, so the repeat check cannot fire after it.
  assign overdue    = now - dl_r;
  assign repeat_due = !accepted && rpt_en && deb_r && !overdue[TIME_W-1];

  always_comb begin
    if (accepted) begin
      dl_nxt = now + {{(TIME_W-CFG_W){1'b0}}, cfg.first_rpt};
    end else if (repeat_due) begin
      dl_nxt = now + {{(TIME_W-CFG_W){1'b0}}, cfg.rpt_intvl};
    end else begin
      dl_nxt = dl_r;
    end
  end

  assign hit = (accepted && pressed) || repeat_due;

  // Lane state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r <= 1'b0;
      deb_r <= 1'b0;
      lct_r <= '0;
      dl_r  <= '0;
    end else if (upd) begin
      raw_r <= raw_nxt;
      deb_r <= deb_nxt;
      lct_r <= lct_nxt;
      dl_r  <= dl_nxt;
    end
  end

endmodule

/* sv/skda_merge.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Six-key debounce and auto-repeat: merge stage
// Picks the lowest-numbered key with an event, tells the lanes up to and
// including it to commit their state, and forms the event code.
// ---------------------------------------------------------------------------
module skda_merge import skda_pkg::*; (
  input  logic [KEY_COUNT-1:0] hit,
  output merge_t               res
);

  logic blocked;

  // Priority scan from key 0 upward; keys after the first event stay as they were.
  always_comb begin
    blocked = 1'b0;
    res     = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      res.commit[i] = !blocked;
      res.first[i]  = hit[i] && !blocked;
      if (res.first[i]) begin
        res.code = res.code | EVT_W'(i + 1);
      end
      blocked = blocked || hit[i];
    end
  end

endmodule

/* sv/six_key_debounce_autorepeat.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Six-key debounce and auto-repeat: top level
// Debounces six active-low key pins polled with a millisecond timestamp and
// yields one key event word per poll, with per-key auto-repeat.
//
//   Channel  Direction  Handshake              Word
//   in       to block   in_valid / in_ready    in_time_now, in_pin_levels
//   out      from block out_valid / out_ready  out_key_event
//   cfg      to block   psel/penable/pready    paddr, pwdata, prdata
//
// One poll is taken per cycle while in_ready is high; its event word appears in
// the output register on the next cycle. All six lanes and the priority merge
// settle in the accepting cycle, so lane state is current for a poll in the very
// next cycle. in_ready is high whenever the output register is empty or being
// drained. Reset restores the register defaults and clears all key state at once.
// ---------------------------------------------------------------------------
module six_key_debounce_autorepeat import skda_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Poll channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TIME_W-1:0] in_time_now,
  input  logic [PIN_W-1:0]  in_pin_levels,
  // Event channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EVT_W-1:0]  out_key_event,
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0]     debounce_r;
  logic [CFG_W-1:0]     first_rpt_r;
  logic [CFG_W-1:0]     rpt_intvl_r;
  logic [MASK_W-1:0]    rpt_mask_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  cfg_t                 cfg;

  logic                 in_acc;
  logic [KEY_COUNT-1:0] hit;
  merge_t               mrg;

  logic                 out_valid_r, out_valid_nxt;
  logic [EVT_W-1:0]     key_event_r;

  // Register port: always ready, word-aligned registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= RST_DEBOUNCE;
      first_rpt_r <= RST_FIRST_RPT;
      rpt_intvl_r <= RST_RPT_INTVL;
      rpt_mask_r  <= RST_RPT_MASK;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE:  debounce_r  <= pwdata[CFG_W-1:0];
        REG_FIRST_RPT: first_rpt_r <= pwdata[CFG_W-1:0];
        REG_RPT_INTVL: rpt_intvl_r <= pwdata[CFG_W-1:0];
        REG_RPT_MASK:  rpt_mask_r  <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:  prdata = {{(DATA_W-CFG_W){1'b0}}, debounce_r};
      REG_FIRST_RPT: prdata = {{(DATA_W-CFG_W){1'b0}}, first_rpt_r};
      REG_RPT_INTVL: prdata = {{(DATA_W-CFG_W){1'b0}}, rpt_intvl_r};
      REG_RPT_MASK:  prdata = {{(DATA_W-MASK_W){1'b0}}, rpt_mask_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.debounce  = debounce_r;
  assign cfg.first_rpt = first_rpt_r;
  assign cfg.rpt_intvl = rpt_intvl_r;

  // Input handshake: accept while the output register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Key lanes. Pins past the field read as pressed, mask bits past it as off.
  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_lane
    logic pressed;
    logic rpt_en;
    if (g < PIN_W) begin : g_pin
      assign pressed = !in_pin_levels[g];
    end else begin : g_nopin
      assign pressed = 1'b1;
    end
    if (g < MASK_W) begin : g_msk
      assign rpt_en = rpt_mask_r[g];
    end else begin : g_nomsk
      assign rpt_en = 1'b0;
    end
    skda_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .now     (in_time_now),
      .pressed (pressed),
      .cfg     (cfg),
      .rpt_en  (rpt_en),
      .upd     (in_acc && mrg.commit[g]),
      .hit     (hit[g])
    );
  end

  // Priority merge across lanes.
  skda_merge u_merge (
    .hit (hit),
    .res (mrg)
  );

  // Output register: one event word per accepted poll.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_event_r <= mrg.code;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_event = key_event_r;

  // Checks on the merge and the output register.
  a_one_winner: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(mrg.first))
    else $error("more than one lane chosen to end the poll");

  a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
    (mrg.first == '0) == (mrg.code == '0))
    else $error("event code disagrees with the chosen lane");

  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid && (out_key_event == $past(mrg.code)))
    else $error("accepted poll did not load the output register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with the output register free");

endmodule
